// ----- sv/sdc_pkg.sv -----
`default_nettype none
package sdc_pkg;

    // coordinate and register widths
    localparam int CW     = 32;
    localparam int CFG_IW = 2;
    localparam int RW     = CW - 1;

    // datapath widths
    localparam int DW   = CW + 1;
    localparam int AW   = 2 * DW;
    localparam int BW   = AW + 1;
    localparam int CCW  = BW + 1;
    localparam int G1W  = CCW + 2;
    localparam int RRW  = 2 * RW;
    localparam int ARW  = AW + RRW;
    localparam int CRW  = 2 * AW;
    localparam int DFW  = CRW + 1;
    localparam int SQ_W = ARW;
    localparam int RT_W = SQ_W / 2;
    localparam int RM_W = RT_W + 1;
    localparam int SQS  = RT_W;
    localparam int NW   = BW + 2;
    localparam int NMW  = NW - 1;
    localparam int CH   = 23;
    localparam int CH2  = NMW - 2 * CH;
    localparam int QW   = DW + 2;
    localparam int PRW  = DW + NMW;
    localparam int WKW  = PRW + 1;
    localparam int LANE_STAGES = QW + 4;

    localparam logic [CFG_IW-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_RADIUS   = 2'd2;

    typedef enum logic [2:0] {
        CASE_MISS,
        CASE_TANGENT,
        CASE_INSIDE,
        CASE_CHORD,
        CASE_ENTERS,
        CASE_LEAVES
    } case_t;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } in_t;

    typedef struct packed {
        logic                 hit;
        logic [2:0]           clip_case;
        logic signed [CW-1:0] clip_first_x;
        logic signed [CW-1:0] clip_first_y;
        logic signed [CW-1:0] clip_last_x;
        logic signed [CW-1:0] clip_last_y;
    } out_t;

    // sideband that rides along the square root pipeline
    typedef struct packed {
        in_t                  seg;
        logic [AW-1:0]        a;
        logic signed [BW-1:0] b;
        case_t                clip_case;
    } sq_side_t;

endpackage
`default_nettype wire

// ----- sv/sdc_front.sv -----
`default_nettype none
module sdc_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire sdc_pkg::in_t                   in_data,
    input  wire logic signed [sdc_pkg::CW-1:0]  center_x,
    input  wire logic signed [sdc_pkg::CW-1:0]  center_y,
    input  wire logic [sdc_pkg::RW-1:0]         radius,
    output logic                                out_valid,
    output logic [sdc_pkg::SQ_W-1:0]            out_dsq,
    output sdc_pkg::sq_side_t                   out_side
);

    typedef struct packed {
        logic azero;
        logic bneg;
        logic bzero;
        logic c0neg;
        logic c0zero;
        logic c1neg;
        logic c1zero;
        logic abpos;
        logic abneg;
    } flags_t;

    logic [7:0] vld_reg;

    sdc_pkg::sq_side_t side1_reg, side2_reg, side3_reg, side4_reg;
    sdc_pkg::sq_side_t side5_reg, side6_reg, side7_reg, side_out_reg;
    sdc_pkg::sq_side_t side1_next, side3_next, side_out_next;

    logic signed [sdc_pkg::DW-1:0] dx1_reg, dy1_reg, fx1_reg, fy1_reg;

    logic signed [sdc_pkg::AW-1:0] pxx2_reg, pyy2_reg, pxf2_reg, pyf2_reg;
    logic signed [sdc_pkg::AW-1:0] pxg2_reg, pyg2_reg, pff2_reg, pgg2_reg;
    logic [sdc_pkg::RRW-1:0]       prr2_reg;

    logic signed [sdc_pkg::BW-1:0]  cr3_reg;
    logic signed [sdc_pkg::CCW-1:0] c3_reg;
    logic [sdc_pkg::RRW-1:0]        rr3_reg;

    logic [sdc_pkg::AW-1:0]         abscr4_reg;
    logic signed [sdc_pkg::G1W-1:0] g14_reg;
    logic signed [sdc_pkg::CCW-1:0] ab4_reg;
    logic signed [sdc_pkg::CCW-1:0] c4_reg;
    logic [sdc_pkg::RRW-1:0]        rr4_reg;

    logic [sdc_pkg::DW+sdc_pkg::RW-1:0] ahrh5_reg, ahrl5_reg, alrh5_reg, alrl5_reg;
    logic [sdc_pkg::AW-1:0]             chch5_reg, chcl5_reg, clcl5_reg;
    flags_t                             fl5_reg, fl6_reg, fl7_reg;

    logic [sdc_pkg::ARW-1:0]        ar6_reg;
    logic [sdc_pkg::CRW-1:0]        cr6_reg;
    logic signed [sdc_pkg::DFW-1:0] d7_reg;

    logic [sdc_pkg::SQ_W-1:0] dsq_out_reg;

    logic [sdc_pkg::AW-1:0]         a3_next;
    logic signed [sdc_pkg::BW-1:0]  b3_next;
    sdc_pkg::case_t                 case_next;
    logic                           t1ge0, t1le1, t2ge0, t2le1;

    always_comb begin
        a3_next = sdc_pkg::AW'(pxx2_reg) + sdc_pkg::AW'(pyy2_reg);
        b3_next = sdc_pkg::BW'(pxf2_reg) + sdc_pkg::BW'(pyf2_reg);
        side1_next = '0;
        side1_next.seg = in_data;
        side3_next = side2_reg;
        side3_next.a = a3_next;
        side3_next.b = b3_next;
    end

    // root position against 0 and 1 from the signs of the quadratic's ends
    always_comb begin
        t1ge0 = !fl7_reg.c0neg && fl7_reg.bneg;
        t1le1 = fl7_reg.c1neg || fl7_reg.c1zero || fl7_reg.abpos;
        t2ge0 = fl7_reg.c0neg || fl7_reg.c0zero || fl7_reg.bneg;
        t2le1 = !fl7_reg.c1neg && fl7_reg.abpos;
        case_next = sdc_pkg::CASE_MISS;
        if (fl7_reg.azero) begin
            case_next = sdc_pkg::CASE_MISS;
        end else if (d7_reg == '0) begin
            if ((fl7_reg.bneg || fl7_reg.bzero) && !fl7_reg.abneg) begin
                case_next = sdc_pkg::CASE_TANGENT;
            end
        end else if (d7_reg > 0) begin
            if (!t2ge0 || !t1le1) begin
                case_next = sdc_pkg::CASE_MISS;
            end else if ((fl7_reg.c0neg || fl7_reg.c0zero) &&
                         (fl7_reg.c1neg || fl7_reg.c1zero)) begin
                case_next = sdc_pkg::CASE_INSIDE;
            end else if (t1ge0 && t2le1) begin
                case_next = sdc_pkg::CASE_CHORD;
            end else if (t1ge0) begin
                case_next = sdc_pkg::CASE_ENTERS;
            end else begin
                case_next = sdc_pkg::CASE_LEAVES;
            end
        end
    end

    always_comb begin
        side_out_next = side7_reg;
        side_out_next.clip_case = case_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // differences
            side1_reg <= side1_next;
            dx1_reg <= sdc_pkg::DW'(in_data.end_x) - sdc_pkg::DW'(in_data.start_x);
            dy1_reg <= sdc_pkg::DW'(in_data.end_y) - sdc_pkg::DW'(in_data.start_y);
            fx1_reg <= sdc_pkg::DW'(in_data.start_x) - sdc_pkg::DW'(center_x);
            fy1_reg <= sdc_pkg::DW'(in_data.start_y) - sdc_pkg::DW'(center_y);

            // products
            side2_reg <= side1_reg;
            pxx2_reg <= sdc_pkg::AW'(dx1_reg) * sdc_pkg::AW'(dx1_reg);
            pyy2_reg <= sdc_pkg::AW'(dy1_reg) * sdc_pkg::AW'(dy1_reg);
            pxf2_reg <= sdc_pkg::AW'(dx1_reg) * sdc_pkg::AW'(fx1_reg);
            pyf2_reg <= sdc_pkg::AW'(dy1_reg) * sdc_pkg::AW'(fy1_reg);
            pxg2_reg <= sdc_pkg::AW'(dx1_reg) * sdc_pkg::AW'(fy1_reg);
            pyg2_reg <= sdc_pkg::AW'(dy1_reg) * sdc_pkg::AW'(fx1_reg);
            pff2_reg <= sdc_pkg::AW'(fx1_reg) * sdc_pkg::AW'(fx1_reg);
            pgg2_reg <= sdc_pkg::AW'(fy1_reg) * sdc_pkg::AW'(fy1_reg);
            prr2_reg <= sdc_pkg::RRW'(radius) * sdc_pkg::RRW'(radius);

            // quadratic coefficients and cross product
            side3_reg <= side3_next;
            cr3_reg <= sdc_pkg::BW'(pxg2_reg) - sdc_pkg::BW'(pyg2_reg);
            c3_reg  <= sdc_pkg::CCW'(pff2_reg) + sdc_pkg::CCW'(pgg2_reg)
                       - sdc_pkg::CCW'(prr2_reg);
            rr3_reg <= prr2_reg;

            side4_reg  <= side3_reg;
            abscr4_reg <= sdc_pkg::AW'(cr3_reg[sdc_pkg::BW-1] ? -cr3_reg : cr3_reg);
            g14_reg <= sdc_pkg::G1W'(side3_reg.a) + (sdc_pkg::G1W'(side3_reg.b) <<< 1)
                       + sdc_pkg::G1W'(c3_reg);
            ab4_reg <= sdc_pkg::CCW'(side3_reg.a) + sdc_pkg::CCW'(side3_reg.b);
            c4_reg  <= c3_reg;
            rr4_reg <= rr3_reg;

            // partial products of a*r^2 and cross^2, disc = a*r^2 - cross^2
            side5_reg <= side4_reg;
            ahrh5_reg <= (sdc_pkg::DW+sdc_pkg::RW)'(side4_reg.a[sdc_pkg::AW-1:sdc_pkg::DW])
                         * (sdc_pkg::DW+sdc_pkg::RW)'(rr4_reg[sdc_pkg::RRW-1:sdc_pkg::RW]);
            ahrl5_reg <= (sdc_pkg::DW+sdc_pkg::RW)'(side4_reg.a[sdc_pkg::AW-1:sdc_pkg::DW])
                         * (sdc_pkg::DW+sdc_pkg::RW)'(rr4_reg[sdc_pkg::RW-1:0]);
            alrh5_reg <= (sdc_pkg::DW+sdc_pkg::RW)'(side4_reg.a[sdc_pkg::DW-1:0])
                         * (sdc_pkg::DW+sdc_pkg::RW)'(rr4_reg[sdc_pkg::RRW-1:sdc_pkg::RW]);
            alrl5_reg <= (sdc_pkg::DW+sdc_pkg::RW)'(side4_reg.a[sdc_pkg::DW-1:0])
                         * (sdc_pkg::DW+sdc_pkg::RW)'(rr4_reg[sdc_pkg::RW-1:0]);
            chch5_reg <= sdc_pkg::AW'(abscr4_reg[sdc_pkg::AW-1:sdc_pkg::DW])
                         * sdc_pkg::AW'(abscr4_reg[sdc_pkg::AW-1:sdc_pkg::DW]);
            chcl5_reg <= sdc_pkg::AW'(abscr4_reg[sdc_pkg::AW-1:sdc_pkg::DW])
                         * sdc_pkg::AW'(abscr4_reg[sdc_pkg::DW-1:0]);
            clcl5_reg <= sdc_pkg::AW'(abscr4_reg[sdc_pkg::DW-1:0])
                         * sdc_pkg::AW'(abscr4_reg[sdc_pkg::DW-1:0]);
            fl5_reg.azero  <= side4_reg.a == '0;
            fl5_reg.bneg   <= side4_reg.b < 0;
            fl5_reg.bzero  <= side4_reg.b == '0;
            fl5_reg.c0neg  <= c4_reg < 0;
            fl5_reg.c0zero <= c4_reg == '0;
            fl5_reg.c1neg  <= g14_reg < 0;
            fl5_reg.c1zero <= g14_reg == '0;
            fl5_reg.abpos  <= ab4_reg > 0;
            fl5_reg.abneg  <= ab4_reg < 0;

            side6_reg <= side5_reg;
            fl6_reg   <= fl5_reg;
            ar6_reg <= (sdc_pkg::ARW'(ahrh5_reg) << (sdc_pkg::DW + sdc_pkg::RW))
                       + (sdc_pkg::ARW'(ahrl5_reg) << sdc_pkg::DW)
                       + (sdc_pkg::ARW'(alrh5_reg) << sdc_pkg::RW)
                       + sdc_pkg::ARW'(alrl5_reg);
            cr6_reg <= (sdc_pkg::CRW'(chch5_reg) << (2 * sdc_pkg::DW))
                       + (sdc_pkg::CRW'(chcl5_reg) << (sdc_pkg::DW + 1))
                       + sdc_pkg::CRW'(clcl5_reg);

            side7_reg <= side6_reg;
            fl7_reg   <= fl6_reg;
            d7_reg    <= sdc_pkg::DFW'(ar6_reg) - sdc_pkg::DFW'(cr6_reg);

            side_out_reg <= side_out_next;
            dsq_out_reg <= (d7_reg > 0) ? d7_reg[sdc_pkg::SQ_W-1:0] : '0;
        end
    end

    assign out_valid = vld_reg[7];
    assign out_dsq   = dsq_out_reg;
    assign out_side  = side_out_reg;

endmodule
`default_nettype wire

// ----- sv/sdc_sqrt.sv -----
`default_nettype none
module sdc_sqrt (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [sdc_pkg::SQ_W-1:0]    in_dsq,
    input  wire sdc_pkg::sq_side_t           in_side,
    output logic                             out_valid,
    output logic [sdc_pkg::RT_W-1:0]         out_root,
    output sdc_pkg::sq_side_t                out_side
);

    logic [sdc_pkg::SQ_W-1:0] x_reg    [sdc_pkg::SQS];
    logic [sdc_pkg::RM_W-1:0] rm_reg   [sdc_pkg::SQS];
    logic [sdc_pkg::RT_W-1:0] rt_reg   [sdc_pkg::SQS];
    sdc_pkg::sq_side_t        side_reg [sdc_pkg::SQS];
    logic [sdc_pkg::SQS-1:0]  vld_reg;

    // one root bit per stage, two radicand bits brought down each time
    for (genvar k = 0; k < sdc_pkg::SQS; k++) begin : g_st
        logic [sdc_pkg::SQ_W-1:0]  xs;
        logic [sdc_pkg::RM_W-1:0]  rs;
        logic [sdc_pkg::RT_W-1:0]  ts;
        sdc_pkg::sq_side_t         ss;
        logic                      vs;
        logic [sdc_pkg::RM_W+1:0]  rem2;
        logic [sdc_pkg::RM_W+1:0]  trial;
        logic                      ge;

        if (k == 0) begin : g_first
            assign xs = in_dsq;
            assign rs = '0;
            assign ts = '0;
            assign ss = in_side;
            assign vs = in_valid;
        end else begin : g_next
            assign xs = x_reg[k-1];
            assign rs = rm_reg[k-1];
            assign ts = rt_reg[k-1];
            assign ss = side_reg[k-1];
            assign vs = vld_reg[k-1];
        end

        assign rem2  = {rs, xs[sdc_pkg::SQ_W-1 -: 2]};
        assign trial = (sdc_pkg::RM_W+2)'({ts, 2'b01});
        assign ge    = rem2 >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k]    <= xs << 2;
                rm_reg[k]   <= sdc_pkg::RM_W'(ge ? rem2 - trial : rem2);
                rt_reg[k]   <= {ts[sdc_pkg::RT_W-2:0], ge};
                side_reg[k] <= ss;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vs;
            end
        end
    end

    assign out_valid = vld_reg[sdc_pkg::SQS-1];
    assign out_root  = rt_reg[sdc_pkg::SQS-1];
    assign out_side  = side_reg[sdc_pkg::SQS-1];

endmodule
`default_nettype wire

// ----- sv/sdc_lane.sv -----
`default_nettype none
module sdc_lane (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [sdc_pkg::CW-1:0] p0,
    input  wire logic signed [sdc_pkg::CW-1:0] p1,
    input  wire logic signed [sdc_pkg::NW-1:0] num,
    input  wire logic [sdc_pkg::AW-1:0]        a,
    output logic signed [sdc_pkg::CW-1:0]      v
);

    localparam int PPW = sdc_pkg::DW + sdc_pkg::CH;
    localparam int VW  = sdc_pkg::QW + 2;

    logic [sdc_pkg::NMW-1:0]        nm1_reg;
    logic [sdc_pkg::DW-1:0]         dm1_reg;
    logic                           sgn1_reg, sgn2_reg, sgn3_reg;
    logic signed [sdc_pkg::CW-1:0]  p0_1_reg, p1_1_reg, p0_2_reg, p1_2_reg;
    logic signed [sdc_pkg::CW-1:0]  p0_3_reg, p1_3_reg;
    logic [sdc_pkg::AW-1:0]         a1_reg, a2_reg, a3_reg;
    logic [PPW-1:0]                 pp0_reg, pp1_reg, pp2_reg;
    logic [sdc_pkg::WKW-1:0]        wk3_reg;

    logic [sdc_pkg::WKW-1:0]        wk_reg  [sdc_pkg::QW];
    logic [sdc_pkg::AW-1:0]         a_reg   [sdc_pkg::QW];
    logic signed [sdc_pkg::CW-1:0]  p0_reg  [sdc_pkg::QW];
    logic signed [sdc_pkg::CW-1:0]  p1_reg  [sdc_pkg::QW];
    logic                           sgn_reg [sdc_pkg::QW];

    logic signed [sdc_pkg::DW-1:0]  dl;
    logic [sdc_pkg::PRW-1:0]        prod;
    logic signed [VW-1:0]           sum, lo, hi, clamp;
    logic [sdc_pkg::QW-1:0]         q;
    logic signed [sdc_pkg::CW-1:0]  pf0, pf1;
    logic                           sgnf;
    logic signed [sdc_pkg::CW-1:0]  v_reg;

    always_comb begin
        dl   = sdc_pkg::DW'(p1) - sdc_pkg::DW'(p0);
        prod = sdc_pkg::PRW'(pp0_reg) + (sdc_pkg::PRW'(pp1_reg) << sdc_pkg::CH)
               + (sdc_pkg::PRW'(pp2_reg) << (2 * sdc_pkg::CH));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // magnitudes and sign of delta * num
            nm1_reg  <= sdc_pkg::NMW'(num[sdc_pkg::NW-1] ? -num : num);
            dm1_reg  <= sdc_pkg::DW'(dl[sdc_pkg::DW-1] ? -dl : dl);
            sgn1_reg <= num[sdc_pkg::NW-1] ^ dl[sdc_pkg::DW-1];
            p0_1_reg <= p0;
            p1_1_reg <= p1;
            a1_reg   <= a;

            pp0_reg <= PPW'(dm1_reg) * PPW'(nm1_reg[sdc_pkg::CH-1:0]);
            pp1_reg <= PPW'(dm1_reg) * PPW'(nm1_reg[2*sdc_pkg::CH-1:sdc_pkg::CH]);
            pp2_reg <= PPW'(dm1_reg) * PPW'(nm1_reg[sdc_pkg::NMW-1 -: sdc_pkg::CH2]);
            sgn2_reg <= sgn1_reg;
            p0_2_reg <= p0_1_reg;
            p1_2_reg <= p1_1_reg;
            a2_reg   <= a1_reg;

            // dividend for round to nearest: 2*|n| + a over 2*a
            wk3_reg  <= sdc_pkg::WKW'({prod, 1'b0}) + sdc_pkg::WKW'(a2_reg);
            sgn3_reg <= sgn2_reg;
            p0_3_reg <= p0_2_reg;
            p1_3_reg <= p1_2_reg;
            a3_reg   <= a2_reg;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < sdc_pkg::QW; k++) begin : g_div
        logic [sdc_pkg::WKW-1:0]       ws;
        logic [sdc_pkg::AW-1:0]        as;
        logic signed [sdc_pkg::CW-1:0] p0s, p1s;
        logic                          sg;
        logic [sdc_pkg::AW+1:0]        rem2;
        logic [sdc_pkg::AW+1:0]        den;
        logic                          ge;
        logic [sdc_pkg::AW:0]          rnew;

        if (k == 0) begin : g_first
            assign ws  = wk3_reg;
            assign as  = a3_reg;
            assign p0s = p0_3_reg;
            assign p1s = p1_3_reg;
            assign sg  = sgn3_reg;
        end else begin : g_next
            assign ws  = wk_reg[k-1];
            assign as  = a_reg[k-1];
            assign p0s = p0_reg[k-1];
            assign p1s = p1_reg[k-1];
            assign sg  = sgn_reg[k-1];
        end

        assign rem2 = ws[sdc_pkg::WKW-1:sdc_pkg::QW-1];
        assign den  = {1'b0, as, 1'b0};
        assign ge   = rem2 >= den;
        assign rnew = (sdc_pkg::AW+1)'(ge ? rem2 - den : rem2);

        always_ff @(posedge aclk) begin
            if (en) begin
                wk_reg[k]  <= {rnew, ws[sdc_pkg::QW-2:0], ge};
                a_reg[k]   <= as;
                p0_reg[k]  <= p0s;
                p1_reg[k]  <= p1s;
                sgn_reg[k] <= sg;
            end
        end
    end

    always_comb begin
        q    = wk_reg[sdc_pkg::QW-1][sdc_pkg::QW-1:0];
        pf0  = p0_reg[sdc_pkg::QW-1];
        pf1  = p1_reg[sdc_pkg::QW-1];
        sgnf = sgn_reg[sdc_pkg::QW-1];
        sum  = VW'(pf0) + (sgnf ? -VW'(q) : VW'(q));
        lo   = (pf0 < pf1) ? VW'(pf0) : VW'(pf1);
        hi   = (pf0 < pf1) ? VW'(pf1) : VW'(pf0);
        clamp = sum;
        if (sum < lo) begin
            clamp = lo;
        end
        if (sum > hi) begin
            clamp = hi;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg <= sdc_pkg::CW'(clamp);
        end
    end

    assign v = v_reg;

endmodule
`default_nettype wire

// ----- sv/segment_disk_clip_2d_top.sv -----
`default_nettype none
// Clips a 2D segment (signed Q16.16 end points) to the closed disk set by center_x,
// center_y and radius, and returns the clipped end points with a case code (miss,
// tangent, inside, chord, enters, leaves). Fully pipelined: one segment per clock.
// The stages in order: the exact quadratic and discriminant, the bit-per-stage square
// root, the root numerators, the multiply and bit-per-stage rounding divider per
// coordinate, and the output register. The whole pipeline holds when the output word
// is not taken. Write configuration only while no word is in flight.
module segment_disk_clip_2d_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire sdc_pkg::in_t                     s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output sdc_pkg::out_t                         m_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sdc_pkg::CFG_IW-1:0]       cfg_index,
    input  wire logic [sdc_pkg::CW-1:0]           cfg_data
);

    logic signed [sdc_pkg::CW-1:0] center_x_reg, center_y_reg;
    logic [sdc_pkg::RW-1:0]        radius_reg;

    logic                          en;
    logic                          fr_valid;
    logic [sdc_pkg::SQ_W-1:0]      fr_dsq;
    sdc_pkg::sq_side_t             fr_side;
    logic                          sq_valid;
    logic [sdc_pkg::RT_W-1:0]      sq_root;
    sdc_pkg::sq_side_t             sq_side;

    logic                          n_vld_reg;
    logic signed [sdc_pkg::NW-1:0] n1_reg, n2_reg;
    sdc_pkg::sq_side_t             n_side_reg;

    logic                   dl_vld_reg  [sdc_pkg::LANE_STAGES];
    sdc_pkg::case_t         dl_case_reg [sdc_pkg::LANE_STAGES];
    sdc_pkg::in_t           dl_seg_reg  [sdc_pkg::LANE_STAGES];

    logic signed [sdc_pkg::CW-1:0] f_x, f_y, l_x, l_y;
    sdc_pkg::out_t                 out_next;
    sdc_pkg::out_t                 out_reg;
    logic                          m_valid_reg;
    sdc_pkg::case_t                cs;
    sdc_pkg::in_t                  sg;

    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                sdc_pkg::CFG_CENTER_X: center_x_reg <= cfg_data;
                sdc_pkg::CFG_CENTER_Y: center_y_reg <= cfg_data;
                sdc_pkg::CFG_RADIUS:   radius_reg   <= cfg_data[sdc_pkg::RW-1:0];
                default: ;
            endcase
        end
    end

    sdc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .radius    (radius_reg),
        .out_valid (fr_valid),
        .out_dsq   (fr_dsq),
        .out_side  (fr_side)
    );

    sdc_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_dsq    (fr_dsq),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // root numerators -b - s and -b + s; equal on a tangent since s is zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_vld_reg <= 1'b0;
        end else if (en) begin
            n_vld_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_reg     <= -sdc_pkg::NW'(sq_side.b) - sdc_pkg::NW'(sq_root);
            n2_reg     <= -sdc_pkg::NW'(sq_side.b) + sdc_pkg::NW'(sq_root);
            n_side_reg <= sq_side;
        end
    end

    sdc_lane u_lane_fx (
        .aclk (aclk), .en (en),
        .p0 (n_side_reg.seg.start_x), .p1 (n_side_reg.seg.end_x),
        .num (n1_reg), .a (n_side_reg.a), .v (f_x)
    );

    sdc_lane u_lane_fy (
        .aclk (aclk), .en (en),
        .p0 (n_side_reg.seg.start_y), .p1 (n_side_reg.seg.end_y),
        .num (n1_reg), .a (n_side_reg.a), .v (f_y)
    );

    sdc_lane u_lane_lx (
        .aclk (aclk), .en (en),
        .p0 (n_side_reg.seg.start_x), .p1 (n_side_reg.seg.end_x),
        .num (n2_reg), .a (n_side_reg.a), .v (l_x)
    );

    sdc_lane u_lane_ly (
        .aclk (aclk), .en (en),
        .p0 (n_side_reg.seg.start_y), .p1 (n_side_reg.seg.end_y),
        .num (n2_reg), .a (n_side_reg.a), .v (l_y)
    );

    // case and end points wait alongside the lanes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < sdc_pkg::LANE_STAGES; i++) begin
                dl_vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            for (int i = sdc_pkg::LANE_STAGES - 1; i > 0; i--) begin
                dl_vld_reg[i] <= dl_vld_reg[i-1];
            end
            dl_vld_reg[0] <= n_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = sdc_pkg::LANE_STAGES - 1; i > 0; i--) begin
                dl_case_reg[i] <= dl_case_reg[i-1];
                dl_seg_reg[i]  <= dl_seg_reg[i-1];
            end
            dl_case_reg[0] <= n_side_reg.clip_case;
            dl_seg_reg[0]  <= n_side_reg.seg;
        end
    end

    always_comb begin
        cs = dl_case_reg[sdc_pkg::LANE_STAGES-1];
        sg = dl_seg_reg[sdc_pkg::LANE_STAGES-1];
        out_next = '0;
        out_next.clip_case = cs;
        out_next.hit = cs != sdc_pkg::CASE_MISS;
        case (cs)
            sdc_pkg::CASE_TANGENT: begin
                out_next.clip_first_x = f_x;
                out_next.clip_first_y = f_y;
                out_next.clip_last_x  = f_x;
                out_next.clip_last_y  = f_y;
            end
            sdc_pkg::CASE_INSIDE: begin
                out_next.clip_first_x = sg.start_x;
                out_next.clip_first_y = sg.start_y;
                out_next.clip_last_x  = sg.end_x;
                out_next.clip_last_y  = sg.end_y;
            end
            sdc_pkg::CASE_CHORD: begin
                out_next.clip_first_x = f_x;
                out_next.clip_first_y = f_y;
                out_next.clip_last_x  = l_x;
                out_next.clip_last_y  = l_y;
            end
            sdc_pkg::CASE_ENTERS: begin
                out_next.clip_first_x = f_x;
                out_next.clip_first_y = f_y;
                out_next.clip_last_x  = sg.end_x;
                out_next.clip_last_y  = sg.end_y;
            end
            sdc_pkg::CASE_LEAVES: begin
                out_next.clip_first_x = sg.start_x;
                out_next.clip_first_y = sg.start_y;
                out_next.clip_last_x  = l_x;
                out_next.clip_last_y  = l_y;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dl_vld_reg[sdc_pkg::LANE_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef ASSERT_OFF
    a_hit_matches_case: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.hit == (m_data.clip_case != sdc_pkg::CASE_MISS)))
        else $error("hit flag disagrees with case code");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.clip_case == sdc_pkg::CASE_MISS) |->
        (m_data.clip_first_x == '0 && m_data.clip_first_y == '0 &&
         m_data.clip_last_x == '0 && m_data.clip_last_y == '0))
        else $error("miss word carries nonzero points");

    a_tangent_point: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.clip_case == sdc_pkg::CASE_TANGENT) |->
        (m_data.clip_first_x == m_data.clip_last_x &&
         m_data.clip_first_y == m_data.clip_last_y))
        else $error("tangent word with two different points");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input held off without an output stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output word valid right after reset");
`endif

endmodule
`default_nettype wire
